// ===== rtl/u8d_pkg.sv =====
// u8d_pkg: shared types and constants for the utf-8 stream decoder
// holds the result status codes, field widths and the step result struct
// no dependencies

package u8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int ST_W   = 2;
    localparam int REM_W  = 2;

    // result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_BAD   = 2'd1,
        ST_TRUNC = 2'd2
    } status_t;

    // lead byte patterns, matched on the top bits of the byte
    localparam logic [2:0] LEAD2_PAT = 3'b110;
    localparam logic [3:0] LEAD3_PAT = 4'b1110;
    localparam logic [4:0] LEAD4_PAT = 5'b11110;
    localparam logic [1:0] CONT_PAT  = 2'b10;

    // one result from the decode step
    typedef struct packed {
        logic              valid;
        logic [CP_W-1:0]   code_point;
        status_t           status;
    } result_t;

endpackage

// ===== rtl/u8d_step.sv =====
// u8d_step: sequence state and the per-byte decode logic
// updates the pending count, partial code point and bad flag on each step
// depends on u8d_pkg

module u8d_step (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step_en,
    input  logic [u8d_pkg::BYTE_W-1:0]  byte_in,
    input  logic                        end_of_text,
    output u8d_pkg::result_t            result
);
    import u8d_pkg::*;

    logic [REM_W-1:0] rem_reg,  rem_next;
    logic [CP_W-1:0]  part_reg, part_next;
    logic             bad_reg,  bad_next;

    logic [CP_W-1:0]  shifted;
    logic [REM_W-1:0] rem_dec;
    logic             bad_acc;

    assign shifted = {part_reg[CP_W-7:0], byte_in[5:0]};
    assign rem_dec = rem_reg - REM_W'(1);
    assign bad_acc = bad_reg | (byte_in[7:6] != CONT_PAT);

    always_comb begin
        rem_next          = rem_reg;
        part_next         = part_reg;
        bad_next          = bad_reg;
        result.valid      = 1'b0;
        result.code_point = '0;
        result.status     = ST_OK;

        if (rem_reg == '0) begin
            priority if (byte_in[7] == 1'b0) begin
                result.valid      = 1'b1;
                result.code_point = CP_W'(byte_in);
            end else if (byte_in[7:5] == LEAD2_PAT) begin
                part_next = CP_W'(byte_in[4:0]);
                rem_next  = REM_W'(1);
                bad_next  = 1'b0;
            end else if (byte_in[7:4] == LEAD3_PAT) begin
                part_next = CP_W'(byte_in[3:0]);
                rem_next  = REM_W'(2);
                bad_next  = 1'b0;
            end else if (byte_in[7:3] == LEAD4_PAT) begin
                part_next = CP_W'(byte_in[2:0]);
                rem_next  = REM_W'(3);
                bad_next  = 1'b0;
            end else begin
                // stray continuation or 11111xxx passes through as is
                result.valid      = 1'b1;
                result.code_point = CP_W'(byte_in);
            end
            // end of text right on a lead byte
            if (rem_next != '0 && end_of_text) begin
                rem_next      = '0;
                part_next     = '0;
                bad_next      = 1'b0;
                result.valid  = 1'b1;
                result.status = ST_TRUNC;
            end
        end else begin
            part_next = shifted;
            bad_next  = bad_acc;
            rem_next  = rem_dec;
            if (rem_dec == '0) begin
                part_next     = '0;
                bad_next      = 1'b0;
                result.valid  = 1'b1;
                if (bad_acc) begin
                    result.status = ST_BAD;
                end else begin
                    result.code_point = shifted;
                end
            end else if (end_of_text) begin
                rem_next      = '0;
                part_next     = '0;
                bad_next      = 1'b0;
                result.valid  = 1'b1;
                result.status = ST_TRUNC;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg  <= '0;
            part_reg <= '0;
            bad_reg  <= 1'b0;
        end else if (step_en) begin
            rem_reg  <= rem_next;
            part_reg <= part_next;
            bad_reg  <= bad_next;
        end
    end

endmodule

// ===== rtl/utf8_stream_decoder.sv =====
// an accepted byte is held in the input register; its result is then held in the result register on m_*
// throughput: one byte per cycle while a stalled m_tready does not hold a full result register
// a lead or non-final continuation byte yields no result unless s_tlast gives ST_TRUNC
// reset: aresetn is synchronous, active low; clears both stages and the
// sequence state, so the decoder starts idle with nothing pending
// depends on u8d_pkg and u8d_step

module utf8_stream_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    // input bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tlast,   // end_of_text
    // decoded code points
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
    output logic [1:0]  m_tuser    // [1:0] status
);
    import u8d_pkg::*;

    // input register stage
    logic              in_vld_reg,  in_vld_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // result register stage
    logic              out_vld_reg, out_vld_next;
    logic [CP_W-1:0]   out_cp_reg;
    status_t           out_st_reg;

    result_t           step_res;
    logic              advance;
    logic              in_take;

    // the held byte moves on when the result register is empty or draining
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    // the input register refills in the same cycle it hands its byte on
    assign s_tready = !in_vld_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    u8d_step u_step (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .byte_in     (in_byte_reg),
        .end_of_text (in_last_reg),
        .result      (step_res)
    );

    always_comb begin
        in_vld_next = in_vld_reg;
        if (in_take) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (advance) begin
            // a step with no result leaves the output empty
            out_vld_next = step_res.valid;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && step_res.valid) begin
            out_cp_reg <= step_res.code_point;
            out_st_reg <= step_res.status;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {3'b000, out_cp_reg};
    assign m_tuser  = out_st_reg;

endmodule

// ===== rtl/u8d_checker.sv =====
// u8d_checker: port-level checks for the utf-8 stream decoder
// bound to utf8_stream_decoder; depends on u8d_pkg

module u8d_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic [1:0]  m_tuser
);
    import u8d_pkg::*;

    // output drops after any reset cycle
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // error results carry a zero code point
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_BAD || m_tuser == ST_TRUNC) |-> m_tdata == '0)
        else $error("error result with nonzero code point");

    // only defined status codes, and pad bits stay zero
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_BAD || m_tuser == ST_TRUNC)
                     && m_tdata[23:21] == 3'b000)
        else $error("bad status code or pad bits");

    // input side never blocks while the result side drains
    a_in_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("s_tready low while m_tready high");

endmodule

bind utf8_stream_decoder u8d_checker u_u8d_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
